FILE: rtl/cdtc_pkg.sv
package cdtc_pkg;

  // Field widths
  localparam int unsigned CmdW    = 4;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;

  // Packed stream widths (tdata padded to whole bytes)
  localparam int unsigned FieldsW = MinuteW + HourW + DayW + MonthW + YearW;
  localparam int unsigned DataW   = ((FieldsW + 7) / 8) * 8;
  localparam int unsigned PadW    = DataW - FieldsW;

  // Default upper year limit
  localparam int unsigned YEAR_MAX_DEF = 9999;

  // Command codes
  localparam logic [CmdW-1:0] CMD_LOAD      = 4'd0;
  localparam logic [CmdW-1:0] CMD_INC_MIN   = 4'd1;
  localparam logic [CmdW-1:0] CMD_INC_HOUR  = 4'd2;
  localparam logic [CmdW-1:0] CMD_INC_DAY   = 4'd3;
  localparam logic [CmdW-1:0] CMD_INC_MONTH = 4'd4;
  localparam logic [CmdW-1:0] CMD_INC_YEAR  = 4'd5;
  localparam logic [CmdW-1:0] CMD_DEC_MIN   = 4'd6;
  localparam logic [CmdW-1:0] CMD_DEC_HOUR  = 4'd7;
  localparam logic [CmdW-1:0] CMD_DEC_DAY   = 4'd8;
  localparam logic [CmdW-1:0] CMD_DEC_MONTH = 4'd9;
  localparam logic [CmdW-1:0] CMD_DEC_YEAR  = 4'd10;

  // Calendar limits
  localparam logic [MinuteW-1:0] MINUTE_LAST = 6'd59;
  localparam logic [HourW-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MonthW-1:0]  MONTH_FEB   = 4'd2;
  localparam logic [MonthW-1:0]  MONTH_LAST  = 4'd12;
  localparam logic [DayW-1:0]    FEB_LEAP    = 5'd29;
  localparam logic [DayW-1:0]    FEB_COMMON  = 5'd28;

  // Month lengths, indexed by month code; unused codes read 31
  localparam logic [DayW-1:0] MONTH_DAYS [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // Length of a month; leap year when year mod 4 is zero
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                              input logic [YearW-1:0]  year);
    logic [DayW-1:0] len;
    if (month == MONTH_FEB) begin
      len = (year[1:0] == 2'd0) ? FEB_LEAP : FEB_COMMON;
    end else begin
      len = MONTH_DAYS[month];
    end
    return len;
  endfunction

endpackage

FILE: rtl/calendar_date_time_counter.sv
// Calendar date/time counter. Each stream transaction carries a command in
// s_axis_tuser: load all fields (each range checked, a bad field keeps its
// old value and sets the error flag) or step minute, hour, day, month or
// year up or down by one with full carry/borrow. Every command returns one
// transaction holding the whole calendar and the error flag. An accepted
// transaction passes the input register, then the calendar/result register,
// before its result is offered; a new command is taken every cycle while the
// result side keeps up, as the carry chain that updates the calendar
// registers is combinational. The year
// holds at 1 and YEAR_MAX: a step past either end changes nothing and flags
// an error. Unused commands change nothing and report no error.
module calendar_date_time_counter #(
  parameter int unsigned YEAR_MAX = cdtc_pkg::YEAR_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // load_minute, load_hour, load_day, load_month, load_year, zero pad
  input  logic [cdtc_pkg::DataW-1:0]   s_axis_tdata,
  // command
  input  logic [cdtc_pkg::CmdW-1:0]    s_axis_tuser,
  // master side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // cur_minute, cur_hour, cur_day, cur_month, cur_year, zero pad
  output logic [cdtc_pkg::DataW-1:0]   m_axis_tdata,
  // error_flag
  output logic                         m_axis_tuser
);

  localparam int unsigned MinW = cdtc_pkg::MinuteW;
  localparam int unsigned HrW  = cdtc_pkg::HourW;
  localparam int unsigned DyW  = cdtc_pkg::DayW;
  localparam int unsigned MoW  = cdtc_pkg::MonthW;
  localparam int unsigned YrW  = cdtc_pkg::YearW;
  localparam logic [YrW-1:0] YearMax = YrW'(YEAR_MAX);

  // Input register
  logic                 in_valid_q;
  logic [MinW-1:0]      ld_min_q;
  logic [HrW-1:0]       ld_hour_q;
  logic [DyW-1:0]       ld_day_q;
  logic [MoW-1:0]       ld_month_q;
  logic [YrW-1:0]       ld_year_q;
  logic [cdtc_pkg::CmdW-1:0] cmd_q;

  // Calendar state and result
  logic [MinW-1:0] min_q,   min_d;
  logic [HrW-1:0]  hour_q,  hour_d;
  logic [DyW-1:0]  day_q,   day_d;
  logic [MoW-1:0]  month_q, month_d;
  logic [YrW-1:0]  year_q,  year_d;
  logic            err_q,   err_d;
  logic            out_valid_q;
  logic            step_fail;

  logic advance;
  logic in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q      <= s_axis_tuser;
      ld_min_q   <= s_axis_tdata[MinW-1:0];
      ld_hour_q  <= s_axis_tdata[MinW+HrW-1:MinW];
      ld_day_q   <= s_axis_tdata[MinW+HrW+DyW-1:MinW+HrW];
      ld_month_q <= s_axis_tdata[MinW+HrW+DyW+MoW-1:MinW+HrW+DyW];
      ld_year_q  <= s_axis_tdata[MinW+HrW+DyW+MoW+YrW-1:MinW+HrW+DyW+MoW];
    end
  end

  // Next calendar value
  always_comb begin
    logic            is_inc, is_dec;
    logic            sel_min, sel_hour, sel_day, sel_month, sel_year;
    logic            min_end, hour_end, day_end, month_end;
    logic            c_hour, c_day, c_month, c_year;
    logic            from_day;
    logic [DyW-1:0]  cur_len, new_len, day_mid;
    logic            ok_min, ok_hour, ok_month, ok_year, ok_day;

    is_inc = 1'b0;
    is_dec = 1'b0;
    if (cmd_q inside {[cdtc_pkg::CMD_INC_MIN:cdtc_pkg::CMD_INC_YEAR]}) is_inc = 1'b1;
    if (cmd_q inside {[cdtc_pkg::CMD_DEC_MIN:cdtc_pkg::CMD_DEC_YEAR]}) is_dec = 1'b1;
    sel_min   = (cmd_q == cdtc_pkg::CMD_INC_MIN)   || (cmd_q == cdtc_pkg::CMD_DEC_MIN);
    sel_hour  = (cmd_q == cdtc_pkg::CMD_INC_HOUR)  || (cmd_q == cdtc_pkg::CMD_DEC_HOUR);
    sel_day   = (cmd_q == cdtc_pkg::CMD_INC_DAY)   || (cmd_q == cdtc_pkg::CMD_DEC_DAY);
    sel_month = (cmd_q == cdtc_pkg::CMD_INC_MONTH) || (cmd_q == cdtc_pkg::CMD_DEC_MONTH);
    sel_year  = (cmd_q == cdtc_pkg::CMD_INC_YEAR)  || (cmd_q == cdtc_pkg::CMD_DEC_YEAR);

    cur_len = cdtc_pkg::days_in(month_q, year_q);

    // Wrap conditions differ by direction
    if (is_dec) begin
      min_end   = (min_q == '0);
      hour_end  = (hour_q == '0);
      day_end   = (day_q <= DyW'(1));
      month_end = (month_q <= MoW'(1));
    end else begin
      min_end   = (min_q >= cdtc_pkg::MINUTE_LAST);
      hour_end  = (hour_q >= cdtc_pkg::HOUR_LAST);
      day_end   = (day_q >= cur_len);
      month_end = (month_q >= cdtc_pkg::MONTH_LAST);
    end

    // Carry/borrow chain
    c_hour   = (sel_min && min_end) || sel_hour;
    c_day    = (c_hour && hour_end) || sel_day;
    c_month  = (c_day && day_end) || sel_month;
    c_year   = (c_month && month_end) || sel_year;
    from_day = is_dec && c_day && day_end;

    min_d   = min_q;
    hour_d  = hour_q;
    day_mid = day_q;
    month_d = month_q;
    year_d  = year_q;
    err_d   = 1'b0;
    step_fail = 1'b0;
    ok_min = 1'b0; ok_hour = 1'b0; ok_month = 1'b0; ok_year = 1'b0; ok_day = 1'b0;

    if (is_inc) begin
      if (sel_min)  min_d  = min_end  ? '0 : min_q + MinW'(1);
      if (c_hour)   hour_d = hour_end ? '0 : hour_q + HrW'(1);
      if (c_day)    day_mid = day_end ? DyW'(1) : day_q + DyW'(1);
      if (c_month)  month_d = month_end ? MoW'(1) : month_q + MoW'(1);
      if (c_year)   year_d = year_q + YrW'(1);
      step_fail = c_year && (year_q >= YearMax);
    end else if (is_dec) begin
      if (sel_min)  min_d  = min_end  ? cdtc_pkg::MINUTE_LAST : min_q - MinW'(1);
      if (c_hour)   hour_d = hour_end ? cdtc_pkg::HOUR_LAST : hour_q - HrW'(1);
      if (c_day && !day_end) day_mid = day_q - DyW'(1);
      if (c_month)  month_d = month_end ? cdtc_pkg::MONTH_LAST : month_q - MoW'(1);
      if (c_year)   year_d = year_q - YrW'(1);
      step_fail = c_year && (year_q <= YrW'(1));
    end else if (cmd_q == cdtc_pkg::CMD_LOAD) begin
      ok_min   = (ld_min_q <= cdtc_pkg::MINUTE_LAST);
      ok_hour  = (ld_hour_q <= cdtc_pkg::HOUR_LAST);
      ok_month = (ld_month_q >= MoW'(1)) && (ld_month_q <= cdtc_pkg::MONTH_LAST);
      ok_year  = (ld_year_q >= YrW'(1)) && (ld_year_q <= YearMax);
      if (ok_min)   min_d   = ld_min_q;
      if (ok_hour)  hour_d  = ld_hour_q;
      if (ok_month) month_d = ld_month_q;
      if (ok_year)  year_d  = ld_year_q;
    end

    // Length of the month that results; day is checked and clamped against it
    new_len = cdtc_pkg::days_in(month_d, year_d);
    if (cmd_q == cdtc_pkg::CMD_LOAD) begin
      ok_day = (ld_day_q >= DyW'(1)) && (ld_day_q <= new_len);
      if (ok_day) day_mid = ld_day_q;
      err_d = !(ok_min && ok_hour && ok_month && ok_year && ok_day);
    end

    if (from_day) begin
      day_d = new_len;
    end else if (day_mid > new_len) begin
      day_d = new_len;
    end else begin
      day_d = day_mid;
    end

    // Step past a year limit leaves the calendar as it was
    if (step_fail) begin
      min_d   = min_q;
      hour_d  = hour_q;
      day_d   = day_q;
      month_d = month_q;
      year_d  = year_q;
      err_d   = 1'b1;
    end
  end

  // Calendar registers double as the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= '0;
      hour_q      <= '0;
      day_q       <= DyW'(1);
      month_q     <= MoW'(1);
      year_q      <= YrW'(1);
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        min_q   <= min_d;
        hour_q  <= hour_d;
        day_q   <= day_d;
        month_q <= month_d;
        year_q  <= year_d;
        err_q   <= err_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{cdtc_pkg::PadW{1'b0}}, year_q, month_q, day_q, hour_q, min_q};
  assign m_axis_tuser  = err_q;

  // Calendar always holds a legal date
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= MoW'(1)) && (month_q <= cdtc_pkg::MONTH_LAST))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_q >= DyW'(1)) && (day_q <= cdtc_pkg::days_in(month_q, year_q)))
    else $error("day out of range for month");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (year_q >= YrW'(1)) && (year_q <= YearMax))
    else $error("year out of range");

  // A step past a year limit must leave the calendar untouched and flag it
  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_fail) |=> ($stable(year_q) && $stable(month_q) && $stable(day_q)
                                && $stable(hour_q) && $stable(min_q) && err_q))
    else $error("calendar changed on year limit");

  // Input stage never accepts while it holds a command and a result is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline stalled");

endmodule

FILE: bench/calendar_checker.sv
`timescale 1ns / 100ps

module calendar_checker #(
  parameter int unsigned YEAR_MAX = cdtc_pkg::YEAR_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command side
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  // load_minute, load_hour, load_day, load_month, load_year, zero pad
  input  logic [cdtc_pkg::DataW-1:0] s_axis_tdata,
  // command
  input  logic [cdtc_pkg::CmdW-1:0]  s_axis_tuser,
  // calendar side
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // cur_minute, cur_hour, cur_day, cur_month, cur_year, zero pad
  input  logic [cdtc_pkg::DataW-1:0] m_axis_tdata,
  // error_flag
  input  logic                       m_axis_tuser,
  output int                         fail_cnt_o,
  output int                         pending_o
);

  // Minute sits in the low bits, so it is the last member of the packed struct
  typedef struct packed {
    logic [cdtc_pkg::YearW-1:0]   year;
    logic [cdtc_pkg::MonthW-1:0]  month;
    logic [cdtc_pkg::DayW-1:0]    day;
    logic [cdtc_pkg::HourW-1:0]   hour;
    logic [cdtc_pkg::MinuteW-1:0] minute;
  } cal_t;

  typedef struct packed {
    cal_t cal;
    logic err;
  } calendar_result_t;

  cal_t             cal_q;
  calendar_result_t due_q[$];
  int               fail_cnt;

  // Month length, leap year every fourth year
  function automatic logic [cdtc_pkg::DayW-1:0] month_len(
      input logic [cdtc_pkg::MonthW-1:0] m,
      input logic [cdtc_pkg::YearW-1:0]  y);
    logic [cdtc_pkg::DayW-1:0] len;
    case (m)
      cdtc_pkg::MONTH_FEB:     len = (y % 4 == 0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic cal_t clamp_day(input cal_t c);
    if (c.day > month_len(c.month, c.year)) c.day = month_len(c.month, c.year);
    return c;
  endfunction

  // unit: 0 minute .. 4 year; returns 0 when the year would pass its top
  function automatic bit count_up(inout cal_t c, input int unsigned unit);
    int unsigned u;
    u = unit;
    if (u == 0) begin
      if (c.minute < cdtc_pkg::MINUTE_LAST) begin
        c.minute = c.minute + 1'b1;
        return 1'b1;
      end
      c.minute = '0;
      u = 1;
    end
    if (u == 1) begin
      if (c.hour < cdtc_pkg::HOUR_LAST) begin
        c.hour = c.hour + 1'b1;
        return 1'b1;
      end
      c.hour = '0;
      u = 2;
    end
    if (u == 2) begin
      if (c.day < month_len(c.month, c.year)) begin
        c.day = c.day + 1'b1;
        return 1'b1;
      end
      c.day = 5'd1;
      u = 3;
    end
    if (u == 3) begin
      if (c.month < cdtc_pkg::MONTH_LAST) begin
        c.month = c.month + 1'b1;
        c = clamp_day(c);
        return 1'b1;
      end
      c.month = 4'd1;
    end
    if (c.year >= YEAR_MAX) return 1'b0;
    c.year = c.year + 1'b1;
    c = clamp_day(c);
    return 1'b1;
  endfunction

  // Borrow out of the day lands on the last day of the previous month
  function automatic bit count_down(inout cal_t c, input int unsigned unit);
    bit          from_day;
    int unsigned u;
    from_day = 1'b0;
    u = unit;
    if (u == 0) begin
      if (c.minute > 0) begin
        c.minute = c.minute - 1'b1;
        return 1'b1;
      end
      c.minute = cdtc_pkg::MINUTE_LAST;
      u = 1;
    end
    if (u == 1) begin
      if (c.hour > 0) begin
        c.hour = c.hour - 1'b1;
        return 1'b1;
      end
      c.hour = cdtc_pkg::HOUR_LAST;
      u = 2;
    end
    if (u == 2) begin
      if (c.day > 1) begin
        c.day = c.day - 1'b1;
        return 1'b1;
      end
      from_day = 1'b1;
      u = 3;
    end
    if (u == 3) begin
      if (c.month > 1) begin
        c.month = c.month - 1'b1;
      end else begin
        if (c.year <= 1) return 1'b0;
        c.month = cdtc_pkg::MONTH_LAST;
        c.year = c.year - 1'b1;
      end
      if (from_day) c.day = month_len(c.month, c.year);
      else c = clamp_day(c);
      return 1'b1;
    end
    if (c.year <= 1) return 1'b0;
    c.year = c.year - 1'b1;
    c = clamp_day(c);
    return 1'b1;
  endfunction

  // Calendar after one command, with the error flag
  function automatic calendar_result_t next_calendar(
      input logic [cdtc_pkg::CmdW-1:0]  cmd,
      input logic [cdtc_pkg::DataW-1:0] data,
      input cal_t                       cur);
    cal_t             ld;
    cal_t             c;
    cal_t             w;
    calendar_result_t r;
    bit               ok;
    ld = cal_t'(data[cdtc_pkg::FieldsW-1:0]);
    c = cur;
    r.err = 1'b0;
    if (cmd == cdtc_pkg::CMD_LOAD) begin
      if (ld.minute <= cdtc_pkg::MINUTE_LAST) c.minute = ld.minute; else r.err = 1'b1;
      if (ld.hour <= cdtc_pkg::HOUR_LAST) c.hour = ld.hour; else r.err = 1'b1;
      if (ld.month >= 1 && ld.month <= cdtc_pkg::MONTH_LAST) c.month = ld.month;
      else r.err = 1'b1;
      if (ld.year >= 1 && ld.year <= YEAR_MAX) c.year = ld.year; else r.err = 1'b1;
      // day is judged against the month and year after the load
      if (ld.day >= 1 && ld.day <= month_len(c.month, c.year)) c.day = ld.day;
      else r.err = 1'b1;
      c = clamp_day(c);
    end else if (cmd <= cdtc_pkg::CMD_DEC_YEAR) begin
      w = c;
      if (cmd <= cdtc_pkg::CMD_INC_YEAR) ok = count_up(w, 32'(cmd - cdtc_pkg::CMD_INC_MIN));
      else ok = count_down(w, 32'(cmd - cdtc_pkg::CMD_DEC_MIN));
      if (ok) c = w;
      else r.err = 1'b1;
    end
    r.cal = c;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare finished transactions, then predict newly accepted commands
  always @(posedge clk_i or negedge rst_ni) begin
    calendar_result_t got;
    calendar_result_t want;
    if (!rst_ni) begin
      cal_q = '{year: 14'd1, month: 4'd1, day: 5'd1, hour: '0, minute: '0};
      due_q.delete();
      fail_cnt = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cal = cal_t'(m_axis_tdata[cdtc_pkg::FieldsW-1:0]);
        got.err = m_axis_tuser;
        if (due_q.size() == 0) begin
          $error("calendar transaction with no command outstanding: %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = due_q.pop_front();
          check_field("cur_minute", 32'(want.cal.minute), 32'(got.cal.minute));
          check_field("cur_hour", 32'(want.cal.hour), 32'(got.cal.hour));
          check_field("cur_day", 32'(want.cal.day), 32'(got.cal.day));
          check_field("cur_month", 32'(want.cal.month), 32'(got.cal.month));
          check_field("cur_year", 32'(want.cal.year), 32'(got.cal.year));
          check_field("error_flag", 32'(want.err), 32'(got.err));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_calendar(s_axis_tuser, s_axis_tdata, cal_q);
        cal_q = want.cal;
        due_q.push_back(want);
      end
      fail_cnt_o <= fail_cnt;
      pending_o <= due_q.size();
    end
  end

endmodule

FILE: bench/tb_calendar_date_time_counter.sv
`timescale 1ns / 100ps

module tb_calendar_date_time_counter;

  localparam int unsigned YearMax    = cdtc_pkg::YEAR_MAX_DEF;
  localparam int          NumItems   = 900;
  localparam int          CycleLimit = 400000;
  localparam int          DrainLimit = 2000;
  localparam int          LongHold   = 300;

  typedef logic [cdtc_pkg::CmdW-1:0]    cmd_t;
  typedef logic [cdtc_pkg::MinuteW-1:0] min_t;
  typedef logic [cdtc_pkg::HourW-1:0]   hour_t;
  typedef logic [cdtc_pkg::DayW-1:0]    day_t;
  typedef logic [cdtc_pkg::MonthW-1:0]  mon_t;
  typedef logic [cdtc_pkg::YearW-1:0]   year_t;

  // Command codes the block leaves unused
  localparam cmd_t CMD_UNUSED_LO = 4'd11;
  localparam cmd_t CMD_UNUSED_HI = 4'd15;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [cdtc_pkg::DataW-1:0] s_axis_tdata;
  cmd_t                       s_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [cdtc_pkg::DataW-1:0] m_axis_tdata;
  logic                       m_axis_tuser;

  int fail_cnt;
  int pending_cnt;
  int sent_cnt;
  int cycle_cnt;
  int src_calm;
  int sink_stall;
  int sink_calm;
  bit sink_hold_done;

  calendar_date_time_counter #(
    .YEAR_MAX(YearMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  calendar_checker #(
    .YEAR_MAX(YearMax)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("calendar_date_time_counter verification failed");
      $finish;
    end
  end

  // Calendar sink: random stalls, calm stretches, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    int roll;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
      sink_calm <= 0;
      sink_hold_done <= 1'b0;
    end else if (sink_stall != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (!sink_hold_done && sent_cnt >= 300) begin
      // back up the block until it stalls its command side
      m_axis_tready <= 1'b0;
      sink_hold_done <= 1'b1;
      sink_stall <= LongHold;
    end else if (sink_calm != 0) begin
      m_axis_tready <= 1'b1;
      sink_calm <= sink_calm - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        m_axis_tready <= 1'b1;
        sink_calm <= $urandom_range(30, 80);
      end else if (roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (roll < 96) begin
        m_axis_tready <= 1'b0;
        sink_stall <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        sink_stall <= $urandom_range(10, 40);
      end
    end
  end

  // One command transaction, preceded by a random gap
  task automatic send_cmd(input cmd_t  cmd,
                          input min_t  lmin,
                          input hour_t lhour,
                          input day_t  lday,
                          input mon_t  lmon,
                          input year_t lyear);
    int gap;
    int roll;
    gap = 0;
    if (src_calm > 0) begin
      src_calm--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) src_calm = $urandom_range(30, 80);
      else if (roll < 65) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else if (roll < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {{cdtc_pkg::PadW{1'b0}}, lyear, lmon, lday, lhour, lmin};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt <= sent_cnt + 1;
  endtask

  // Step command; load fields carry junk the block must ignore
  task automatic step(input cmd_t cmd);
    send_cmd(cmd, min_t'($urandom_range(0, 63)), hour_t'($urandom_range(0, 31)),
             day_t'($urandom_range(0, 31)), mon_t'($urandom_range(0, 15)),
             year_t'($urandom_range(0, 16383)));
  endtask

  // Load a date close to some carry or borrow edge, now and then with a bad field
  task automatic load_near_edge();
    min_t  lmin;
    hour_t lhour;
    day_t  lday;
    mon_t  lmon;
    year_t lyear;
    case ($urandom_range(0, 3))
      0:       lmin = cdtc_pkg::MINUTE_LAST;
      1:       lmin = '0;
      default: lmin = min_t'($urandom_range(0, 59));
    endcase
    case ($urandom_range(0, 3))
      0:       lhour = cdtc_pkg::HOUR_LAST;
      1:       lhour = '0;
      default: lhour = hour_t'($urandom_range(0, 23));
    endcase
    case ($urandom_range(0, 5))
      0:       lmon = 4'd1;
      1:       lmon = cdtc_pkg::MONTH_FEB;
      2:       lmon = cdtc_pkg::MONTH_LAST;
      default: lmon = mon_t'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       lyear = 14'd1;
      1:       lyear = year_t'(YearMax);
      2:       lyear = year_t'($urandom_range(1, YearMax / 4) * 4);
      3:       lyear = $urandom_range(0, 1) ? year_t'($urandom_range(1, 3))
                                            : year_t'(YearMax - $urandom_range(0, 3));
      default: lyear = year_t'($urandom_range(1, YearMax));
    endcase
    case ($urandom_range(0, 5))
      0:       lday = 5'd1;
      1:       lday = 5'd28;
      2:       lday = 5'd29;
      3:       lday = 5'd30;
      4:       lday = 5'd31;
      default: lday = day_t'($urandom_range(1, 31));
    endcase
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 4))
        0:       lmin = min_t'($urandom_range(60, 63));
        1:       lhour = hour_t'($urandom_range(24, 31));
        2:       lday = '0;
        3:       lmon = mon_t'($urandom_range(13, 16));  // 16 wraps to month 0
        default: lyear = $urandom_range(0, 1) ? '0
                                              : year_t'($urandom_range(YearMax + 1, 16383));
      endcase
    end
    send_cmd(cdtc_pkg::CMD_LOAD, lmin, lhour, lday, lmon, lyear);
  endtask

  // Stimulus and verdict
  initial begin
    int waited;
    bit drained;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    sent_cnt <= 0;
    src_calm = 0;
    drained = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // year floor straight out of reset
    step(cdtc_pkg::CMD_DEC_MIN);
    step(cdtc_pkg::CMD_DEC_YEAR);
    step(cdtc_pkg::CMD_DEC_MONTH);
    // every field but the day out of range, then every field at zero
    send_cmd(cdtc_pkg::CMD_LOAD, '1, '1, '1, '1, '1);
    send_cmd(cdtc_pkg::CMD_LOAD, '0, '0, '0, '0, '0);
    // year ceiling from the last minute of the last year
    send_cmd(cdtc_pkg::CMD_LOAD, cdtc_pkg::MINUTE_LAST, cdtc_pkg::HOUR_LAST, 5'd31,
             cdtc_pkg::MONTH_LAST, year_t'(YearMax));
    step(cdtc_pkg::CMD_INC_MIN);
    step(cdtc_pkg::CMD_INC_HOUR);
    step(cdtc_pkg::CMD_INC_DAY);
    step(cdtc_pkg::CMD_INC_MONTH);
    step(cdtc_pkg::CMD_INC_YEAR);
    // leap day into a common year clamps the day
    send_cmd(cdtc_pkg::CMD_LOAD, 6'd30, 5'd12, 5'd29, cdtc_pkg::MONTH_FEB, 14'd2024);
    step(cdtc_pkg::CMD_INC_YEAR);
    // leap day rejected in a common year
    send_cmd(cdtc_pkg::CMD_LOAD, '0, '0, 5'd29, cdtc_pkg::MONTH_FEB, 14'd2023);
    // month step clamps the day into February
    send_cmd(cdtc_pkg::CMD_LOAD, '0, '0, 5'd31, 4'd3, 14'd2024);
    step(cdtc_pkg::CMD_DEC_MONTH);
    // day borrow lands on the last day of February
    send_cmd(cdtc_pkg::CMD_LOAD, '0, '0, 5'd1, 4'd3, 14'd2023);
    step(cdtc_pkg::CMD_DEC_MIN);
    step(cdtc_pkg::CMD_INC_DAY);
    step(cdtc_pkg::CMD_DEC_DAY);
    send_cmd(cdtc_pkg::CMD_LOAD, 6'd15, '0, 5'd31, 4'd1, 14'd2023);
    step(cdtc_pkg::CMD_INC_MONTH);
    step(cdtc_pkg::CMD_DEC_HOUR);
    // day 31 rejected in April
    send_cmd(cdtc_pkg::CMD_LOAD, '0, '0, 5'd31, 4'd4, 14'd2023);
    // unused commands leave the calendar alone
    step(CMD_UNUSED_LO);
    step(CMD_UNUSED_HI);

    // Random part: edge loads followed by runs of steps, plus some noise
    while (sent_cnt < NumItems) begin
      if ($urandom_range(0, 9) < 8) begin
        load_near_edge();
        repeat ($urandom_range(3, 20))
          step(cmd_t'($urandom_range(cdtc_pkg::CMD_INC_MIN, cdtc_pkg::CMD_DEC_YEAR)));
      end else begin
        repeat ($urandom_range(1, 5))
          send_cmd(cmd_t'($urandom_range(0, 15)), min_t'($urandom_range(0, 63)),
                   hour_t'($urandom_range(0, 31)), day_t'($urandom_range(0, 31)),
                   mon_t'($urandom_range(0, 15)), year_t'($urandom_range(0, 16383)));
      end
      if (!drained && sent_cnt >= 600) begin
        // let the block run dry before going on
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_cnt != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // Drain, then allow the pipeline to settle
    waited = 0;
    while (pending_cnt != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("calendar_date_time_counter verification clean");
    end else begin
      $display("calendar_date_time_counter verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cdtc_pkg.sv
rtl/calendar_date_time_counter.sv
bench/calendar_checker.sv
bench/tb_calendar_date_time_counter.sv
